// ===== rtl/gea_pkg.sv =====
// ----------------------------------------------------------------------------
// gea_pkg
// shared constants and types of the generational entity allocator
// ----------------------------------------------------------------------------
package gea_pkg;

  localparam int MAX_ENTITIES = 1024;
  localparam int IDX_W        = $clog2(MAX_ENTITIES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int GEN_WIDTH    = 32;
  localparam int HGEN_W       = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);

  // request kinds, any other code is a check
  localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR_POP,
    S_CR_GEN,
    S_LOOK,
    S_DENSE,
    S_MOVE,
    S_FIXUP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                handle_valid;
    logic [IDX_W-1:0]    new_index;
    logic [HGEN_W-1:0]   new_generation;
    logic [IDX_W-1:0]    dense_slot;
    logic                moved_valid;
    logic [IDX_W-1:0]    moved_index;
  } result_t;

endpackage

// ===== rtl/gea_ram.sv =====
// ----------------------------------------------------------------------------
// gea_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/generational_entity_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_entity_allocator
// hands out (index, generation) handles and keeps a packed list of live ones
// ----------------------------------------------------------------------------
// latency from input transfer to out_valid is least for a create from a fresh
//   index or when full, then check, then free-stack create; destroy varies
// one item in flight; the next input transfer is taken once the result sits
//   in the output register, and the path an item takes is set by the chain
//   of dependent registered ram reads (entity table, dense list, free stack)
// reset clears the counters and control only; the four tables get no
//   clearing pass; read data of an entry is used only after it is written
module generational_entity_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gea_pkg::KIND_W-1:0]    in_kind,
  input  logic [gea_pkg::IDX_W-1:0]     in_handle_index,
  input  logic [gea_pkg::HGEN_W-1:0]    in_handle_generation,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gea_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_handle_valid,
  output logic [gea_pkg::IDX_W-1:0]     out_new_index,
  output logic [gea_pkg::HGEN_W-1:0]    out_new_generation,
  output logic [gea_pkg::IDX_W-1:0]     out_dense_slot,
  output logic                          out_moved_valid,
  output logic [gea_pkg::IDX_W-1:0]     out_moved_index
);
  import gea_pkg::*;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic [CNT_W-1:0]  live_cnt_r, live_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // request and working registers
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [HGEN_W-1:0]    hgen_r, hgen_nxt;
  logic [IDX_W-1:0]     ni_r, ni_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [GEN_WIDTH-1:0] gen_r, gen_nxt;
  result_t              res_r, res_nxt;
  result_t              out_r, out_nxt;

  // ram ports
  logic                 gen_we, slot_we, dense_we, free_we;
  logic [IDX_W-1:0]     gen_waddr, slot_waddr, dense_waddr, free_waddr;
  logic [GEN_WIDTH-1:0] gen_wdata;
  logic [IDX_W-1:0]     slot_wdata, dense_wdata, free_wdata;
  logic [IDX_W-1:0]     gen_raddr, slot_raddr, dense_raddr, free_raddr;
  logic [GEN_WIDTH-1:0] gen_rdata;
  logic [IDX_W-1:0]     slot_rdata, dense_rdata, free_rdata;

  // decode helpers
  logic              in_xfer;
  logic              out_load;
  logic              gen_match;
  logic              slot_live;
  logic              dense_hit;
  logic [CNT_W-1:0]  last_slot;
  logic              do_move;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // handle known and generation equal to the stored one (all handle bits)
  assign gen_match = ({1'b0, idx_r} < hw_r) && (HGEN_W'(gen_rdata) == hgen_r);
  // stored slot inside the live part of the dense list
  assign slot_live = ({1'b0, slot_rdata} < live_cnt_r);
  assign dense_hit = (dense_rdata == idx_r);
  assign last_slot = live_cnt_r - CNT_W'(1);
  assign do_move   = (slot_r != last_slot[IDX_W-1:0]);

  // --------------------------------------------------------------------------
  // tables
  // --------------------------------------------------------------------------
  gea_ram #(.WIDTH(GEN_WIDTH), .DEPTH(MAX_ENTITIES)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  gea_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTITIES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gea_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTITIES)) u_dense_ram (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

  gea_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTITIES)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_CREATE) begin
            // pop path needs the stack top first, otherwise finish at once
            state_nxt = (free_cnt_r != '0) ? S_CR_POP : S_EMIT;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_CR_POP: state_nxt = S_CR_GEN;
      S_CR_GEN: state_nxt = S_EMIT;
      S_LOOK: begin
        if (kind_r == KIND_DESTROY && gen_match && slot_live) begin
          state_nxt = S_DENSE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DENSE:  state_nxt = dense_hit ? S_MOVE : S_EMIT;
      S_MOVE:   state_nxt = do_move ? S_FIXUP : S_EMIT;
      S_FIXUP:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath, counters and table accesses
  // --------------------------------------------------------------------------
  always_comb begin
    free_cnt_nxt = free_cnt_r;
    hw_nxt       = hw_r;
    live_cnt_nxt = live_cnt_r;
    kind_nxt     = kind_r;
    idx_nxt      = idx_r;
    hgen_nxt     = hgen_r;
    ni_nxt       = ni_r;
    slot_nxt     = slot_r;
    gen_nxt      = gen_r;
    res_nxt      = res_r;
    out_nxt      = out_r;

    gen_we      = 1'b0;
    gen_waddr   = '0;
    gen_wdata   = '0;
    slot_we     = 1'b0;
    slot_waddr  = '0;
    slot_wdata  = '0;
    dense_we    = 1'b0;
    dense_waddr = '0;
    dense_wdata = '0;
    free_we     = 1'b0;
    free_waddr  = '0;
    free_wdata  = '0;
    gen_raddr   = '0;
    slot_raddr  = '0;
    dense_raddr = '0;
    free_raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_kind;
          idx_nxt  = in_handle_index;
          hgen_nxt = in_handle_generation;
          res_nxt  = '0;
          // lookups for destroy and check start right away
          gen_raddr  = in_handle_index;
          slot_raddr = in_handle_index;
          if (in_kind == KIND_CREATE) begin
            if (free_cnt_r != '0) begin
              free_raddr   = free_cnt_r[IDX_W-1:0] - IDX_W'(1);
              free_cnt_nxt = free_cnt_r - CNT_W'(1);
            end else if (hw_r < MAX_CNT) begin
              // fresh index starts at generation zero
              hw_nxt = hw_r + CNT_W'(1);
              if (live_cnt_r < MAX_CNT) begin
                dense_we     = 1'b1;
                dense_waddr  = live_cnt_r[IDX_W-1:0];
                dense_wdata  = hw_r[IDX_W-1:0];
                slot_we      = 1'b1;
                slot_waddr   = hw_r[IDX_W-1:0];
                slot_wdata   = live_cnt_r[IDX_W-1:0];
                gen_we       = 1'b1;
                gen_waddr    = hw_r[IDX_W-1:0];
                gen_wdata    = '0;
                live_cnt_nxt = live_cnt_r + CNT_W'(1);
                res_nxt.new_index  = hw_r[IDX_W-1:0];
                res_nxt.dense_slot = live_cnt_r[IDX_W-1:0];
              end else begin
                res_nxt.status = ST_FULL;
              end
            end else begin
              res_nxt.status = ST_FULL;
            end
          end
        end
      end
      S_CR_POP: begin
        // stack top arrives, fetch its stored generation
        ni_nxt    = free_rdata;
        gen_raddr = free_rdata;
      end
      S_CR_GEN: begin
        if (live_cnt_r < MAX_CNT) begin
          dense_we     = 1'b1;
          dense_waddr  = live_cnt_r[IDX_W-1:0];
          dense_wdata  = ni_r;
          slot_we      = 1'b1;
          slot_waddr   = ni_r;
          slot_wdata   = live_cnt_r[IDX_W-1:0];
          live_cnt_nxt = live_cnt_r + CNT_W'(1);
          res_nxt.new_index      = ni_r;
          res_nxt.new_generation = HGEN_W'(gen_rdata);
          res_nxt.dense_slot     = live_cnt_r[IDX_W-1:0];
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      S_LOOK: begin
        res_nxt.handle_valid = gen_match;
        res_nxt.status       = gen_match ? ST_OK : ST_STALE;
        gen_nxt  = gen_rdata;
        slot_nxt = slot_rdata;
        if (kind_r == KIND_DESTROY) begin
          if (gen_match && slot_live) begin
            // confirm the dense list points back at this index
            dense_raddr = slot_rdata;
          end else begin
            res_nxt.status = ST_STALE;
          end
        end
      end
      S_DENSE: begin
        if (dense_hit) begin
          dense_raddr = last_slot[IDX_W-1:0];
        end else begin
          res_nxt.status = ST_STALE;
        end
      end
      S_MOVE: begin
        // last entity fills the gap, index retires with a new generation
        if (do_move) begin
          dense_we    = 1'b1;
          dense_waddr = slot_r;
          dense_wdata = dense_rdata;
          res_nxt.moved_valid = 1'b1;
          res_nxt.moved_index = dense_rdata;
        end
        ni_nxt       = dense_rdata;
        live_cnt_nxt = live_cnt_r - CNT_W'(1);
        gen_we       = 1'b1;
        gen_waddr    = idx_r;
        gen_wdata    = gen_r + GEN_WIDTH'(1);
        slot_we      = 1'b1;
        slot_waddr   = idx_r;
        slot_wdata   = '0;
        if (free_cnt_r < MAX_CNT) begin
          free_we      = 1'b1;
          free_waddr   = free_cnt_r[IDX_W-1:0];
          free_wdata   = idx_r;
          free_cnt_nxt = free_cnt_r + CNT_W'(1);
        end
        res_nxt.dense_slot = slot_r;
      end
      S_FIXUP: begin
        // moved entity learns its new slot
        slot_we    = 1'b1;
        slot_waddr = ni_r;
        slot_wdata = slot_r;
      end
      S_EMIT: begin
        if (out_load) begin
          out_nxt = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= '0;
      hw_r        <= '0;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      hw_r        <= hw_nxt;
      live_cnt_r  <= live_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    hgen_r <= hgen_nxt;
    ni_r   <= ni_nxt;
    slot_r <= slot_nxt;
    gen_r  <= gen_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // result port
  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_handle_valid   = out_r.handle_valid;
  assign out_new_index      = out_r.new_index;
  assign out_new_generation = out_r.new_generation;
  assign out_dense_slot     = out_r.dense_slot;
  assign out_moved_valid    = out_r.moved_valid;
  assign out_moved_index    = out_r.moved_index;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // no more indices are live or on the free stack than were handed out
  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_cnt_r} + {1'b0, free_cnt_r}) <= {1'b0, hw_r})
    else $error("live plus free exceeds handed-out indices");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= MAX_CNT)
    else $error("high water beyond table size");

  // a completed removal shrinks the dense list by exactly one
  a_destroy_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> (live_cnt_r == $past(live_cnt_r) - CNT_W'(1)))
    else $error("destroy did not shrink dense list");

  // a move only follows a successful destroy
  a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.moved_valid) |-> (out_r.status == ST_OK && out_r.handle_valid))
    else $error("move reported without successful destroy");

endmodule

// ===== tb/gea_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// gea_scoreboard_pkg
// tracks allocator state per input transfer and checks each result transfer
// ----------------------------------------------------------------------------
package gea_scoreboard_pkg;

  import gea_pkg::*;

  // kinds the rtl package leaves unnamed, both behave as a handle check
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int          REPORT_LIMIT = 10;
  localparam logic [63:0] GEN_MASK     = (64'd1 << GEN_WIDTH) - 64'd1;

  class alloc_scoreboard;
    logic [HGEN_W-1:0] gen_tbl    [MAX_ENTITIES];
    int unsigned       slot_tbl   [MAX_ENTITIES];
    int unsigned       dense_list [MAX_ENTITIES];
    int unsigned       free_stk   [MAX_ENTITIES];
    int unsigned       free_count;
    int unsigned       high_water;
    int unsigned       live_count;
    int unsigned       full_count;
    int unsigned       failures;
    result_t           expected_q [$];

    function bit gen_match(int unsigned idx, logic [HGEN_W-1:0] gen);
      return idx < high_water && gen_tbl[idx] == gen;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                               logic [HGEN_W-1:0] gen);
      result_t           r;
      int unsigned       ni, s, last, m;
      logic [HGEN_W-1:0] ng;
      bit                ok;
      r = '0;
      if (kind == KIND_CREATE) begin
        ok = 1'b1;
        if (free_count > 0) begin
          free_count--;
          ni = free_stk[free_count];
          ng = gen_tbl[ni];
        end else if (high_water < MAX_ENTITIES) begin
          ni = high_water;
          ng = '0;
          high_water++;
        end else begin
          ok = 1'b0;
          ni = 0;
          ng = '0;
        end
        if (ok && live_count < MAX_ENTITIES) begin
          s = live_count;
          dense_list[s] = ni;
          live_count++;
          slot_tbl[ni] = s;
          gen_tbl[ni] = ng;
          r.new_index = IDX_W'(ni);
          r.new_generation = ng;
          r.dense_slot = IDX_W'(s);
        end else begin
          r.status = ST_FULL;
          full_count++;
        end
      end else if (kind == KIND_DESTROY) begin
        r.handle_valid = gen_match(idx, gen);
        if (r.handle_valid && slot_tbl[idx] < live_count
            && dense_list[slot_tbl[idx]] == idx) begin
          s = slot_tbl[idx];
          last = live_count - 1;
          if (s != last) begin
            m = dense_list[last];
            dense_list[s] = m;
            slot_tbl[m] = s;
            r.moved_valid = 1'b1;
            r.moved_index = IDX_W'(m);
          end
          live_count--;
          gen_tbl[idx] = HGEN_W'((64'(gen_tbl[idx]) + 64'd1) & GEN_MASK);
          slot_tbl[idx] = 0;
          if (free_count < MAX_ENTITIES) begin
            free_stk[free_count] = idx;
            free_count++;
          end
          r.dense_slot = IDX_W'(s);
        end else begin
          r.status = ST_STALE;
        end
      end else begin
        r.handle_valid = gen_match(idx, gen);
        r.status = r.handle_valid ? ST_OK : ST_STALE;
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: status=%0d valid=%0d new=%0d/%0d",
                   $time, got.status, got.handle_valid, got.new_index, got.new_generation);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.handle_valid !== want.handle_valid
          || got.new_index !== want.new_index || got.new_generation !== want.new_generation
          || got.dense_slot !== want.dense_slot || got.moved_valid !== want.moved_valid
          || got.moved_index !== want.moved_index) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: mismatch, expected st=%0d hv=%0d new=%0d/%0d slot=%0d mv=%0d/%0d",
                   $time, want.status, want.handle_valid, want.new_index,
                   want.new_generation, want.dense_slot, want.moved_valid, want.moved_index);
          $display("%0t:           actual   st=%0d hv=%0d new=%0d/%0d slot=%0d mv=%0d/%0d",
                   $time, got.status, got.handle_valid, got.new_index,
                   got.new_generation, got.dense_slot, got.moved_valid, got.moved_index);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/generational_entity_allocator_test.sv =====
// ----------------------------------------------------------------------------
// generational_entity_allocator_test
// drives create, destroy and check requests through the allocator with random
// sender gaps and receiver stalls, predicts every result from a shadow copy
// of the handle tables and compares each result transfer field by field
// ----------------------------------------------------------------------------
module generational_entity_allocator_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gea_pkg::*;
  import gea_scoreboard_pkg::*;

  localparam int HOLD_CYCLES    = 400;   // long receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 20;    // settle time after the last result

  logic                clk                  = 1'b0;
  logic                rst_n                = 1'b0;
  logic                in_valid             = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind              = KIND_CREATE;
  logic [IDX_W-1:0]    in_handle_index      = '0;
  logic [HGEN_W-1:0]   in_handle_generation = '0;
  logic                out_valid;
  logic                out_ready            = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_handle_valid;
  logic [IDX_W-1:0]    out_new_index;
  logic [HGEN_W-1:0]   out_new_generation;
  logic [IDX_W-1:0]    out_dense_slot;
  logic                out_moved_valid;
  logic [IDX_W-1:0]    out_moved_index;

  alloc_scoreboard sb;
  int unsigned     burst_left   = 0;
  int unsigned     quiet_cycles = 0;
  bit              hold_req     = 1'b0;

  generational_entity_allocator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_handle_valid     (out_handle_valid),
    .out_new_index        (out_new_index),
    .out_new_generation   (out_new_generation),
    .out_dense_slot       (out_dense_slot),
    .out_moved_valid      (out_moved_valid),
    .out_moved_index      (out_moved_index)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one request and hold it until the input transfer; bursts of
  // back-to-back requests are mostly separated by random gaps with valid low
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic [HGEN_W-1:0] gen);
    int unsigned gap;
    if (burst_left == 0) begin
      // a quarter of the bursts follow the previous one with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid             <= 1'b1;
    in_kind              <= kind;
    in_handle_index      <= idx;
    in_handle_generation <= gen;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, idx, gen);
  endtask

  // stop offering and wait until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // malformed or stale handles: random, freed but matching, wrong generation
  // of a live entity, or an index never handed out
  task automatic send_broken();
    logic [KIND_W-1:0] kind;
    int unsigned       idx;
    logic [HGEN_W-1:0] gen;
    case ($urandom_range(0, 2))
      0:       kind = KIND_DESTROY;
      1:       kind = KIND_CHECK;
      default: kind = KIND_SPARE;
    endcase
    idx = $urandom_range(0, MAX_ENTITIES - 1);
    gen = $urandom;
    case ($urandom_range(0, 3))
      1: if (sb.free_count > 0) begin
        // passes the generation compare but is no longer in the dense list
        idx = sb.free_stk[$urandom_range(0, sb.free_count - 1)];
        gen = sb.gen_tbl[idx];
      end
      2: if (sb.live_count > 0) begin
        idx = sb.dense_list[$urandom_range(0, sb.live_count - 1)];
        gen = sb.gen_tbl[idx] ^ (HGEN_W'(1) << $urandom_range(0, HGEN_W - 1));
      end
      3: if (sb.high_water < MAX_ENTITIES) begin
        idx = $urandom_range(sb.high_water, MAX_ENTITIES - 1);
        gen = $urandom_range(0, 2);
      end
      default: ;
    endcase
    send_item(kind, IDX_W'(idx), gen);
  endtask

  // one random request; the percentages weight create, destroy of a live
  // handle and check of a live handle, whatever is left goes to broken ones
  task automatic send_mixed(input int unsigned create_pct, input int unsigned destroy_pct,
                            input int unsigned check_pct);
    int unsigned       roll;
    int unsigned       idx;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < create_pct) begin
      // handle fields are don't-care on create, keep them toggling
      send_item(KIND_CREATE, IDX_W'($urandom), $urandom);
    end else if (roll < create_pct + destroy_pct + check_pct && sb.live_count > 0) begin
      idx = sb.dense_list[$urandom_range(0, sb.live_count - 1)];
      if (roll < create_pct + destroy_pct) kind = KIND_DESTROY;
      else kind = $urandom_range(0, 1) ? KIND_CHECK : KIND_SPARE;
      send_item(kind, IDX_W'(idx), sb.gen_tbl[idx]);
    end else begin
      send_broken();
    end
  endtask

  // result monitor, every result transfer is checked against the oldest
  // expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(result_t'{status: out_status, handle_valid: out_handle_valid,
                                new_index: out_new_index,
                                new_generation: out_new_generation,
                                dense_slot: out_dense_slot, moved_valid: out_moved_valid,
                                moved_index: out_moved_index});
  end

  // receiver: windows of random stall density, some with no stalls, plus a
  // long hold when the stimulus asks for one
  initial begin : receiver
    int unsigned window_left;
    int unsigned stall_pct;
    window_left = 0;
    stall_pct   = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (window_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
          window_left = $urandom_range(8, 80);
        end
        window_left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned fill_items;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, fresh creates, swap-remove with and without a
    // move, freed handle that still matches, free stack reuse in lifo order,
    // unused kind, generation and index extremes
    send_item(KIND_CHECK,   10'd0,     32'd0);          // nothing handed out yet
    send_item(KIND_DESTROY, 10'd0,     32'd0);          // destroy on empty table
    send_item(KIND_CREATE,  10'h3FF,   32'hFFFF_FFFF);  // fresh index 0
    send_item(KIND_CREATE,  10'd0,     32'd0);          // fresh index 1
    send_item(KIND_CREATE,  10'h155,   32'hAAAA_AAAA);  // fresh index 2
    send_item(KIND_CHECK,   10'd1,     32'd0);
    send_item(KIND_SPARE,   10'd2,     32'd0);          // unused kind acts as check
    send_item(KIND_CHECK,   10'd1,     32'hFFFF_FFFF);  // wrong generation
    send_item(KIND_CHECK,   10'h3FF,   32'd0);          // above high water
    send_item(KIND_DESTROY, 10'd0,     32'd0);          // tail entity moves into slot 0
    send_item(KIND_DESTROY, 10'd0,     32'd1);          // freed, matches, not live
    send_item(KIND_CHECK,   10'd0,     32'd1);          // check alone accepts it
    send_item(KIND_DESTROY, 10'd2,     32'd0);          // another move
    send_item(KIND_DESTROY, 10'd1,     32'd0);          // last entity, no move
    send_item(KIND_DESTROY, 10'd1,     32'd0);          // already destroyed
    send_item(KIND_CREATE,  10'h2AA,   32'h5555_5555);  // reuse from free stack
    send_item(KIND_CREATE,  10'd0,     32'd0);
    send_item(KIND_CREATE,  10'd0,     32'd0);
    send_item(KIND_CREATE,  10'd0,     32'd0);          // stack empty again, fresh 3
    send_item(KIND_DESTROY, 10'd3,     32'hFFFF_FFFF);
    send_item(KIND_DESTROY, 10'h3FF,   32'hFFFF_FFFF);
    send_item(KIND_CHECK,   10'd2,     32'd1);
    send_item(KIND_SPARE,   10'h200,   32'h8000_0000);
    // generation wrap needs 2^32 destroys of one index, out of reach here;
    // the shadow model still wraps the increment

    // sender pause until every result is back
    settle();

    // balanced traffic
    repeat (40) send_mixed(40, 30, 15);

    // receiver holds off while requests keep coming, input side backs up
    hold_req = 1'b1;

    // mostly creates until the table has reported full a few times
    fill_items = 0;
    while (sb.full_count < 4 && fill_items < 1500) begin
      send_mixed(98, 1, 1);
      fill_items++;
    end
    settle();

    // mostly destroys, draining the dense list and filling the free stack
    repeat (40) send_mixed(15, 65, 12);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gea_pkg.sv
rtl/gea_ram.sv
rtl/generational_entity_allocator.sv
tb/gea_scoreboard_pkg.sv
tb/generational_entity_allocator_test.sv
